@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define VQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the usual clk_i / rst_ni of the module.
`define VQ_ASSERT(lbl, prop, msg) \
  `VQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/vqdt_pkg.sv @@
package vqdt_pkg;

  localparam int MaxEntries = 256;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = IdxW + 1;
  localparam int GrpBits    = 3;
  localparam int GrpSize    = 1 << GrpBits;
  localparam int GrpW       = IdxW - GrpBits;
  localparam int AvailW     = 16;
  localparam int RemStepW   = $clog2(AvailW + 1);

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_FREE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_HEAD_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ENQ_WR,
    S_FREE_CHK,
    S_FREE_NXT,
    S_RD_REQ,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    action_e          action;
    logic [63:0]      addr;
    logic [31:0]      len;
    logic [15:0]      flags;
    logic             head;
    logic             tail;
    logic [IdxW-1:0]  idx;
  } item_t;

  typedef struct packed {
    logic             we;
    logic             clr;
    logic [IdxW-1:0]  wr_idx;
    logic [63:0]      addr;
    logic [31:0]      len;
    logic [15:0]      flags;
    logic [IdxW-1:0]  next;
    logic             rd_en;
    logic [IdxW-1:0]  rd_idx;
    logic             ring_we;
    logic [IdxW-1:0]  ring_slot;
    logic [GrpW-1:0]  grp;
    logic [IdxW-1:0]  chk_idx;
  } tbl_cmd_t;

  typedef struct packed {
    logic [63:0]         addr;
    logic [31:0]         len;
    logic [15:0]         flags;
    logic [IdxW-1:0]     next;
    logic [GrpSize-1:0]  busy_grp;
    logic                busy_chk;
  } tbl_rsp_t;

  typedef struct packed {
    status_e            status;
    logic [IdxW-1:0]    desc_index;
    logic [63:0]        entry_addr;
    logic [31:0]        entry_len;
    logic [15:0]        entry_flags;
    logic [IdxW-1:0]    entry_next;
    logic [IdxW-1:0]    ring_slot;
    logic [AvailW-1:0]  ring_index;
    logic [CntW-1:0]    freed_count;
  } result_t;

endpackage

@@ rtl/virtqueue_descriptor_table.sv @@
// Per item: a read requests the entry and returns it with the result; a free walks the chain,
// clearing each entry, and stops at a free or out-of-range entry, at a zero next index or once
// queue-size entries are freed; an enqueue scans 8 entries per cycle for a free one below the
// queue size, or reports full; a beat opening a chain also waits on the ring slot remainder.
// Throughput: one item at a time; a new item is taken while the result beat waits.
// Reset: asynchronous, active low; all entries free, ring index 0, queue size 256.
module virtqueue_descriptor_table
  import vqdt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,   // queue size
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [119:0]  s_axis_tdata,  // buf_addr, buf_len, buf_flags, entry_index
  input  logic [2:0]    s_axis_tuser,  // action, is_head
  input  logic          s_axis_tlast,  // is_tail
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [167:0]  m_axis_tdata,  // desc_index, entry_addr, entry_len, entry_flags,
                                       // entry_next, ring_slot, ring_index, freed_count, pad
  output logic [1:0]    m_axis_tuser   // status
);

  logic [CntW-1:0]    qsize_q;
  logic [CntW-1:0]    n_eff;
  item_t              item;
  tbl_cmd_t           cmd;
  tbl_rsp_t           rsp;
  logic               rem_start;
  logic [AvailW-1:0]  rem_dvd;
  logic               rem_busy;
  logic [CntW-1:0]    rem;
  logic               res_valid;
  logic               res_take;
  result_t            res;
  logic               out_vld_q;
  result_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_q <= CntW'(MaxEntries);
    end else if (cfg_we_i) begin
      qsize_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (qsize_q == '0) begin
      n_eff = CntW'(1);
    end else if (qsize_q > CntW'(MaxEntries)) begin
      n_eff = CntW'(MaxEntries);
    end else begin
      n_eff = qsize_q;
    end
  end

  always_comb begin
    item.action = action_e'(s_axis_tuser[1:0]);
    item.head   = s_axis_tuser[2];
    item.tail   = s_axis_tlast;
    item.addr   = s_axis_tdata[63:0];
    item.len    = s_axis_tdata[95:64];
    item.flags  = s_axis_tdata[111:96];
    item.idx    = s_axis_tdata[119:112];
  end

  vqdt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  vqdt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (n_eff),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

  vqdt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .cmd_o       (cmd),
    .rsp_i       (rsp),
    .rem_start_o (rem_start),
    .rem_dvd_o   (rem_dvd),
    .rem_busy_i  (rem_busy),
    .rem_i       (rem),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // output register: result moves in once the previous beat has gone
  assign res_take = res_valid && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0, out_q.freed_count, out_q.ring_index, out_q.ring_slot,
                          out_q.entry_next, out_q.entry_flags, out_q.entry_len,
                          out_q.entry_addr, out_q.desc_index};

endmodule

@@ rtl/vqdt_table.sv @@
module vqdt_table
  import vqdt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_cmd_t  cmd_i,
  output tbl_rsp_t  rsp_o
);

  logic [63:0]      addr_mem  [MaxEntries];
  logic [31:0]      len_mem   [MaxEntries];
  logic [15:0]      flags_mem [MaxEntries];
  logic [IdxW-1:0]  next_mem  [MaxEntries];
  logic [IdxW-1:0]  ring_mem  [MaxEntries];

  // busy: length nonzero; wrn: entry written since reset
  logic [MaxEntries-1:0] busy_q;
  logic [MaxEntries-1:0] wrn_q;
  logic                  rd_vld_q;

  logic [63:0]      rd_addr_q;
  logic [31:0]      rd_len_q;
  logic [15:0]      rd_flags_q;
  logic [IdxW-1:0]  rd_next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      wrn_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.we) begin
        busy_q[cmd_i.wr_idx] <= (cmd_i.len != '0);
        wrn_q[cmd_i.wr_idx]  <= 1'b1;
      end
      if (cmd_i.clr) begin
        busy_q[cmd_i.wr_idx] <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= wrn_q[cmd_i.rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      addr_mem[cmd_i.wr_idx]  <= cmd_i.addr;
      len_mem[cmd_i.wr_idx]   <= cmd_i.len;
      flags_mem[cmd_i.wr_idx] <= cmd_i.flags;
      next_mem[cmd_i.wr_idx]  <= cmd_i.next;
    end
    if (cmd_i.clr) begin
      len_mem[cmd_i.wr_idx] <= '0;
    end
    if (cmd_i.ring_we) begin
      ring_mem[cmd_i.ring_slot] <= cmd_i.wr_idx;
    end
    if (cmd_i.rd_en) begin
      rd_addr_q  <= addr_mem[cmd_i.rd_idx];
      rd_len_q   <= len_mem[cmd_i.rd_idx];
      rd_flags_q <= flags_mem[cmd_i.rd_idx];
      rd_next_q  <= next_mem[cmd_i.rd_idx];
    end
  end

  always_comb begin
    rsp_o.addr     = rd_vld_q ? rd_addr_q  : '0;
    rsp_o.len      = rd_vld_q ? rd_len_q   : '0;
    rsp_o.flags    = rd_vld_q ? rd_flags_q : '0;
    rsp_o.next     = rd_vld_q ? rd_next_q  : '0;
    for (int k = 0; k < GrpSize; k++) begin
      rsp_o.busy_grp[k] = busy_q[{cmd_i.grp, GrpBits'(k)}];
    end
    rsp_o.busy_chk = busy_q[cmd_i.chk_idx];
  end

endmodule

@@ rtl/vqdt_rem.sv @@
module vqdt_rem
  import vqdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AvailW-1:0]  dividend_i,
  input  logic [CntW-1:0]    divisor_i,
  output logic               busy_o,
  output logic [CntW-1:0]    rem_o
);

  logic [RemStepW-1:0] step_q, step_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [AvailW-1:0]   dvd_q, dvd_d;
  logic [CntW:0]       trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[AvailW-1]};
    if (start_i) begin
      step_d = RemStepW'(AvailW);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (step_q != '0) begin
      step_d = step_q - RemStepW'(1);
      dvd_d  = dvd_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CntW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = (step_q != '0);
  assign rem_o  = rem_q;

endmodule

@@ rtl/vqdt_seq.sv @@
`include "assert_macros.svh"

module vqdt_seq
  import vqdt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CntW-1:0]  n_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            item_i,
  output tbl_cmd_t         cmd_o,
  input  tbl_rsp_t         rsp_i,
  output logic             rem_start_o,
  output logic [AvailW-1:0] rem_dvd_o,
  input  logic             rem_busy_i,
  input  logic [CntW-1:0]  rem_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output result_t          res_o
);

  seq_state_e         state_q, state_d;
  item_t              item_q, item_d;
  logic [GrpW-1:0]    grp_q, grp_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    found_q, found_d;
  logic [IdxW-1:0]    desc_q, desc_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  status_e            status_q, status_d;
  logic               rd_sel_q, rd_sel_d;
  logic [AvailW-1:0]  avail_q, avail_d;

  logic [CntW-1:0]     n_m1;
  logic [GrpW-1:0]     last_grp;
  logic [GrpSize-1:0]  free_vec;
  logic                hit;
  logic [GrpBits-1:0]  hit_sel;

  assign n_m1     = n_i - CntW'(1);
  assign last_grp = n_m1[IdxW-1:GrpBits];

  // free entries of the current scan group that lie below the queue size
  always_comb begin
    hit     = 1'b0;
    hit_sel = '0;
    for (int k = 0; k < GrpSize; k++) begin
      free_vec[k] = !rsp_i.busy_grp[k] && ({1'b0, grp_q, GrpBits'(k)} < n_i);
    end
    for (int k = GrpSize - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        hit     = 1'b1;
        hit_sel = GrpBits'(k);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    grp_d       = grp_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    desc_d      = desc_q;
    slot_d      = slot_q;
    status_d    = status_q;
    rd_sel_d    = rd_sel_q;
    avail_d     = avail_q;
    cmd_o       = '0;
    cmd_o.grp   = grp_q;
    cmd_o.chk_idx = cur_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rem_start_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d   = item_i;
          status_d = ST_OK;
          desc_d   = '0;
          slot_d   = '0;
          cnt_d    = '0;
          rd_sel_d = 1'b0;
          grp_d    = '0;
          cur_d    = item_i.idx;
          case (item_i.action)
            ACT_ENQ: begin
              rem_start_o = item_i.head;
              state_d     = S_SCAN;
            end
            ACT_FREE: begin
              desc_d  = item_i.idx;
              state_d = S_FREE_CHK;
            end
            ACT_READ: begin
              desc_d  = item_i.idx;
              state_d = S_RD_REQ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_d = {grp_q, hit_sel};
          state_d = S_ENQ_WR;
        end else if (grp_q == last_grp) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end

      S_ENQ_WR: begin
        // waits for the ring slot remainder when this beat opens a chain
        if (!rem_busy_i) begin
          cmd_o.we        = 1'b1;
          cmd_o.wr_idx    = found_q;
          cmd_o.addr      = item_q.addr;
          cmd_o.len       = item_q.len;
          cmd_o.flags     = item_q.flags;
          cmd_o.next      = item_q.tail ? '0 : found_q + IdxW'(1);
          cmd_o.ring_we   = item_q.head;
          cmd_o.ring_slot = rem_i[IdxW-1:0];
          desc_d          = found_q;
          if (item_q.head) begin
            slot_d = rem_i[IdxW-1:0];
          end
          if (item_q.tail) begin
            avail_d = avail_q + AvailW'(1);
          end
          state_d = S_DONE;
        end
      end

      S_FREE_CHK: begin
        if (({1'b0, cur_q} >= n_i) || !rsp_i.busy_chk) begin
          if (cnt_q == '0) begin
            status_d = ST_HEAD_FREE;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.clr    = 1'b1;
          cmd_o.wr_idx = cur_q;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = cur_q;
          cnt_d        = cnt_q + CntW'(1);
          state_d      = S_FREE_NXT;
        end
      end

      S_FREE_NXT: begin
        if ((rsp_i.next == '0) || (cnt_q == n_i)) begin
          state_d = S_DONE;
        end else begin
          cur_d   = rsp_i.next;
          state_d = S_FREE_CHK;
        end
      end

      S_RD_REQ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = item_q.idx;
        rd_sel_d     = 1'b1;
        state_d      = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rem_dvd_o = avail_q;

  always_comb begin
    res_o             = '0;
    res_o.status      = status_q;
    res_o.desc_index  = desc_q;
    res_o.ring_slot   = slot_q;
    res_o.ring_index  = avail_q;
    res_o.freed_count = cnt_q;
    if (rd_sel_q) begin
      res_o.entry_addr  = rsp_i.addr;
      res_o.entry_len   = rsp_i.len;
      res_o.entry_flags = rsp_i.flags;
      res_o.entry_next  = rsp_i.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      avail_q <= '0;
    end else begin
      state_q <= state_d;
      avail_q <= avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    grp_q    <= grp_d;
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    found_q  <= found_d;
    desc_q   <= desc_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    rd_sel_q <= rd_sel_d;
  end

  `VQ_ASSERT(a_freed_le_size, (state_q == S_DONE) |-> (cnt_q <= n_i), "freed count above queue size")
  `VQ_ASSERT(a_head_free_none, (state_q == S_DONE && status_q == ST_HEAD_FREE) |-> (cnt_q == '0), "free head reported with entries freed")
  `VQ_ASSERT(a_avail_step, (avail_q != $past(avail_q)) |-> (avail_q == AvailW'($past(avail_q) + AvailW'(1))), "ring index moved by more than one")
  `VQ_ASSERT(a_slot_range, (state_q == S_ENQ_WR && !rem_busy_i && item_q.head) |-> (rem_i < n_i), "ring slot outside queue")

endmodule
